FILE: hdl/stt_pkg.sv
// Package for the source text tokenizer: modes, token kinds, result type, helpers.
package stt_pkg;

   localparam int PosBits = 16;
   localparam logic [PosBits-1:0] PosMax = {PosBits{1'b1}};
   localparam int KwChars = 8;
   localparam int LenBits = $clog2(KwChars + 1);

   typedef enum logic [4:0] {
      M_IDLE, M_WORD, M_NUM_A, M_NUM_B, M_DOT, M_SLASH, M_LINE, M_BLOCK,
      M_BLOCK_STAR, M_STRING, M_CH_OPEN, M_CH_ESC, M_CH_BODY, M_BANG, M_EQ,
      M_LT, M_GT, M_BAR, M_AMP
   } mode_type;

   localparam logic [6:0] K_LPAREN = 7'd0, K_RPAREN = 7'd1, K_LBRACE = 7'd2,
      K_RBRACE = 7'd3, K_COMMA = 7'd4, K_DOT = 7'd5, K_MINUS = 7'd6, K_PLUS = 7'd7,
      K_SEMI = 7'd8, K_SLASH = 7'd9, K_STAR = 7'd10, K_QUEST = 7'd11,
      K_COLON = 7'd12, K_PERCENT = 7'd13, K_NOT = 7'd14, K_EQUAL = 7'd15,
      K_GREATER = 7'd16, K_LESS = 7'd17, K_CARET = 7'd18, K_BAND = 7'd19,
      K_BOR = 7'd20, K_TILDE = 7'd21, K_HASH = 7'd22, K_LBRACK = 7'd23,
      K_RBRACK = 7'd24, K_BSLASH = 7'd25, K_NE = 7'd26, K_EQEQ = 7'd27,
      K_GE = 7'd28, K_LE = 7'd29, K_LOR = 7'd31, K_LAND = 7'd32,
      K_IDENT = 7'd33, K_STRING = 7'd34, K_CHAR = 7'd35, K_INT = 7'd36,
      K_FLOAT = 7'd37, K_ERROR = 7'd67, K_COMMENT = 7'd68, K_END = 7'd69;

   typedef struct packed {
      logic [6:0]         kind;
      logic [PosBits-1:0] start;
      logic [PosBits-1:0] length;
      logic [PosBits-1:0] first_line;
      logic [PosBits-1:0] first_col;
      logic [PosBits-1:0] final_line;
      logic [PosBits-1:0] final_col;
   } token_type;

   typedef struct packed {
      logic [PosBits-1:0] offset;
      logic [PosBits-1:0] line;
      logic [PosBits-1:0] col;
   } pos_type;

   function automatic logic [PosBits-1:0] sat_inc(input logic [PosBits-1:0] v);
      return (v == PosMax) ? v : v + 1'b1;
   endfunction

   function automatic pos_type advance(input pos_type p, input logic [7:0] c);
      pos_type r;
      r.offset = sat_inc(p.offset);
      if (c == 8'h0a) begin
         r.line = sat_inc(p.line);
         r.col  = PosBits'(1);
      end else begin
         r.line = p.line;
         r.col  = sat_inc(p.col);
      end
      return r;
   endfunction

   function automatic logic is_alpha(input logic [7:0] c);
      return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z") || c == "_";
   endfunction

   function automatic logic is_digit(input logic [7:0] c);
      return c >= "0" && c <= "9";
   endfunction

endpackage

FILE: hdl/stt_keyword.sv
// Keyword lookup on the buffered first bytes of a word.
module stt_keyword (
   input  logic [8*stt_pkg::KwChars-1:0] word,
   input  logic [stt_pkg::PosBits-1:0]   length,
   output logic [6:0]                    kind
);
   import stt_pkg::*;

   logic [63:0] w;

   function automatic logic [63:0] pad(input logic [63:0] s, input int n);
      // byte-reverse a right-aligned string literal into little-endian order
      logic [63:0] r;
      r = '0;
      for (int i = 0; i < 8; i++) begin
         if (i < n) r[8*i +: 8] = s[8*(n-1-i) +: 8];
      end
      return r;
   endfunction

   assign w = 64'(word);

   always_comb begin
      kind = K_IDENT;
      if (length == PosBits'(2)) begin
         if (w == pad("or", 2)) kind = 7'd20;
         else if (w == pad("fn", 2)) kind = 7'd41;
         else if (w == pad("if", 2)) kind = 7'd43;
         else if (w == pad("u8", 2)) kind = 7'd57;
         else if (w == pad("s8", 2)) kind = 7'd61;
      end else if (length == PosBits'(3)) begin
         if (w == pad("and", 3)) kind = 7'd19;
         else if (w == pad("for", 3)) kind = 7'd42;
         else if (w == pad("u16", 3)) kind = 7'd58;
         else if (w == pad("u32", 3)) kind = 7'd59;
         else if (w == pad("u64", 3)) kind = 7'd60;
         else if (w == pad("s16", 3)) kind = 7'd62;
         else if (w == pad("s32", 3)) kind = 7'd63;
         else if (w == pad("s64", 3)) kind = 7'd64;
         else if (w == pad("r32", 3)) kind = 7'd65;
         else if (w == pad("r64", 3)) kind = 7'd66;
      end else if (length == PosBits'(4)) begin
         if (w == pad("else", 4)) kind = 7'd38;
         else if (w == pad("this", 4)) kind = 7'd45;
         else if (w == pad("enum", 4)) kind = 7'd46;
         else if (w == pad("true", 4)) kind = 7'd47;
         else if (w == pad("case", 4)) kind = 7'd53;
         else if (w == pad("void", 4)) kind = 7'd56;
      end else if (length == PosBits'(5)) begin
         if (w == pad("print", 5)) kind = 7'd39;
         else if (w == pad("false", 5)) kind = 7'd40;
         else if (w == pad("while", 5)) kind = 7'd48;
         else if (w == pad("break", 5)) kind = 7'd49;
         else if (w == pad("const", 5)) kind = 7'd51;
      end else if (length == PosBits'(6)) begin
         if (w == pad("return", 6)) kind = 7'd44;
         else if (w == pad("switch", 6)) kind = 7'd52;
         else if (w == pad("struct", 6)) kind = 7'd55;
      end else if (length == PosBits'(7)) begin
         if (w == pad("default", 7)) kind = 7'd54;
      end else if (length == PosBits'(8)) begin
         if (w == pad("continue", 8)) kind = 7'd50;
      end
   end
endmodule

FILE: hdl/stt_scan.sv
// Scanner step: state registers and one byte of lexing per accepted word.
module stt_scan (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 step,
   input  logic [7:0]           character,
   input  logic                 end_of_input,
   output logic [1:0]           count,
   output stt_pkg::token_type   tok0,
   output stt_pkg::token_type   tok1
);
   import stt_pkg::*;

   mode_type mode_ff, mode_in;
   pos_type  cur_ff, cur_in, beg_ff, beg_in;
   logic [63:0] word_ff, word_in;
   logic dot_ff, dot_in;
   logic [6:0] kw_kind;
   logic [PosBits-1:0] cur_len;

   assign cur_len = cur_ff.offset - beg_ff.offset;

   stt_keyword u_kw (.word(word_ff), .length(cur_len), .kind(kw_kind));

   function automatic token_type mk(input logic [6:0] k, input pos_type b,
                                    input pos_type e);
      token_type t;
      t.kind = k; t.start = b.offset; t.length = e.offset - b.offset;
      t.first_line = b.line; t.first_col = b.col;
      t.final_line = e.line; t.final_col = e.col;
      return t;
   endfunction

   always_comb begin
      logic [6:0] pk;
      logic [6:0] single;
      logic term, isblank;
      logic [7:0] c;
      pos_type p;
      pk = K_ERROR; single = K_ERROR; term = 1'b0; isblank = 1'b0; p = '0;
      c = character;
      mode_in = mode_ff; cur_in = cur_ff; beg_in = beg_ff;
      word_in = word_ff; dot_in = dot_ff;
      count = 2'd0; tok0 = '0; tok1 = '0;
      unique case (mode_ff)
         M_WORD:              pk = kw_kind;
         M_NUM_A, M_NUM_B:    pk = dot_ff ? K_FLOAT : K_INT;
         M_DOT:               pk = K_DOT;
         M_SLASH:             pk = K_SLASH;
         M_LINE:              pk = K_COMMENT;
         M_BANG:              pk = K_NOT;
         M_EQ:                pk = K_EQUAL;
         M_LT:                pk = K_LESS;
         M_GT:                pk = K_GREATER;
         M_BAR:               pk = K_BOR;
         M_AMP:               pk = K_BAND;
         default:             pk = K_ERROR;
      endcase
      if (end_of_input || c == 8'd0) begin
         if (mode_ff != M_IDLE) begin
            tok0 = mk(pk, beg_ff, cur_ff);
            tok1 = mk(K_END, cur_ff, cur_ff);
            count = 2'd2;
         end else begin
            tok0 = mk(K_END, cur_ff, cur_ff);
            count = 2'd1;
         end
         mode_in = M_IDLE;
         beg_in = cur_ff;
      end else begin
         p = advance(cur_ff, c);
         unique case (mode_ff)
            M_IDLE: term = 1'b0;
            M_WORD: begin
               if (is_alpha(c) || is_digit(c)) begin
                  // merge into the slot; a saturated offset keeps hitting the same one
                  for (int i = 0; i < KwChars; i++) begin
                     if (cur_len == PosBits'(i)) word_in[8*i +: 8] = word_ff[8*i +: 8] | c;
                  end
                  cur_in = p;
               end else term = 1'b1;
            end
            M_NUM_A: begin
               if (is_digit(c)) cur_in = p;
               else if (c == ".") begin
                  cur_in = p; dot_in = 1'b1; mode_in = M_NUM_B;
               end else term = 1'b1;
            end
            M_NUM_B: begin
               if (is_digit(c)) cur_in = p; else term = 1'b1;
            end
            M_DOT: begin
               if (is_digit(c)) begin
                  cur_in = p; dot_in = 1'b1; mode_in = M_NUM_A;
               end else term = 1'b1;
            end
            M_SLASH: begin
               if (c == "*") begin cur_in = p; mode_in = M_BLOCK; end
               else if (c == "/") begin cur_in = p; mode_in = M_LINE; end
               else term = 1'b1;
            end
            M_LINE: begin
               if (c == 8'h0a) term = 1'b1; else cur_in = p;
            end
            M_BLOCK: begin
               cur_in = p;
               if (c == "*") mode_in = M_BLOCK_STAR;
            end
            M_BLOCK_STAR: begin
               cur_in = p;
               if (c == "/") begin
                  tok0 = mk(K_COMMENT, beg_ff, p); count = 2'd1; mode_in = M_IDLE;
               end else if (c != "*") mode_in = M_BLOCK;
            end
            M_STRING: begin
               cur_in = p;
               if (c == 8'h22) begin
                  tok0 = mk(K_STRING, beg_ff, p); count = 2'd1; mode_in = M_IDLE;
               end
            end
            M_CH_OPEN: begin
               cur_in = p;
               mode_in = (c == 8'h5c) ? M_CH_ESC : M_CH_BODY;
            end
            M_CH_ESC: begin cur_in = p; mode_in = M_CH_BODY; end
            M_CH_BODY: begin
               if (c == 8'h27) begin
                  cur_in = p; tok0 = mk(K_CHAR, beg_ff, p); count = 2'd1;
                  mode_in = M_IDLE;
               end else term = 1'b1;
            end
            M_BANG, M_EQ, M_LT, M_GT, M_BAR, M_AMP: begin
               if ((c == "=" && (mode_ff == M_BANG || mode_ff == M_EQ ||
                                 mode_ff == M_LT || mode_ff == M_GT)) ||
                   (c == "|" && mode_ff == M_BAR) || (c == "&" && mode_ff == M_AMP)) begin
                  cur_in = p; count = 2'd1; mode_in = M_IDLE;
                  unique case (mode_ff)
                     M_BANG:  tok0 = mk(K_NE, beg_ff, p);
                     M_EQ:    tok0 = mk(K_EQEQ, beg_ff, p);
                     M_LT:    tok0 = mk(K_LE, beg_ff, p);
                     M_GT:    tok0 = mk(K_GE, beg_ff, p);
                     M_BAR:   tok0 = mk(K_LOR, beg_ff, p);
                     default: tok0 = mk(K_LAND, beg_ff, p);
                  endcase
               end else term = 1'b1;
            end
            default: term = 1'b0;
         endcase
         // idle scan, either directly or after flushing the pending token
         if (mode_ff == M_IDLE || term) begin
            if (term) begin
               tok0 = mk(pk, beg_ff, cur_ff); count = 2'd1; mode_in = M_IDLE;
            end
            isblank = (c == " " || c == 8'h09 || c == 8'h0d || c == 8'h0a);
            cur_in = p;
            if (!isblank) begin
               beg_in = cur_ff;
               if (is_alpha(c)) begin mode_in = M_WORD; word_in = 64'(c); end
               else if (is_digit(c)) begin mode_in = M_NUM_A; dot_in = 1'b0; end
               else begin
                  unique case (c)
                     ".":   mode_in = M_DOT;
                     "/":   mode_in = M_SLASH;
                     8'h22: mode_in = M_STRING;
                     8'h27: mode_in = M_CH_OPEN;
                     "!":   mode_in = M_BANG;
                     "=":   mode_in = M_EQ;
                     "<":   mode_in = M_LT;
                     ">":   mode_in = M_GT;
                     "|":   mode_in = M_BAR;
                     "&":   mode_in = M_AMP;
                     "(":   single = K_LPAREN;
                     ")":   single = K_RPAREN;
                     "{":   single = K_LBRACE;
                     "}":   single = K_RBRACE;
                     ",":   single = K_COMMA;
                     "-":   single = K_MINUS;
                     "+":   single = K_PLUS;
                     ";":   single = K_SEMI;
                     "*":   single = K_STAR;
                     "?":   single = K_QUEST;
                     ":":   single = K_COLON;
                     "%":   single = K_PERCENT;
                     "^":   single = K_CARET;
                     "~":   single = K_TILDE;
                     "#":   single = K_HASH;
                     "[":   single = K_LBRACK;
                     "]":   single = K_RBRACK;
                     8'h5c: single = K_BSLASH;
                     default: single = K_ERROR;
                  endcase
                  if (mode_in == M_IDLE) begin
                     if (term) begin tok1 = mk(single, cur_ff, p); count = 2'd2; end
                     else begin tok0 = mk(single, cur_ff, p); count = 2'd1; end
                  end
               end
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff <= M_IDLE;
         cur_ff  <= '{offset: '0, line: PosBits'(1), col: PosBits'(1)};
         beg_ff  <= '{offset: '0, line: PosBits'(1), col: PosBits'(1)};
         word_ff <= '0;
         dot_ff  <= 1'b0;
      end else if (step) begin
         mode_ff <= mode_in;
         cur_ff  <= cur_in;
         beg_ff  <= beg_in;
         word_ff <= word_in;
         dot_ff  <= dot_in;
      end
   end
endmodule

FILE: hdl/source_text_tokenizer_top.sv
// Source text tokenizer: one source byte per ready cycle, up to two tokens out.
//
// Input word (req_): tdata[7:0] = character, tuser = end_of_input.
// A zero byte or end_of_input flushes the pending token and emits the end token.
// Output word (rsp_): tdata packs kind and six 16-bit positions; tlast marks
// the last token caused by one input word.
// Each input byte is scanned in the cycle it is accepted; its tokens sit in a
// two-entry result buffer and appear the next cycle. Throughput is one byte
// per cycle while every byte gives at most one token and the receiver is
// ready; a byte that gives two tokens holds req_tready low while both sit in
// the buffer, which the single output port drains one token at a time.
// When the receiver stalls, the buffer fills and req_tready drops; nothing
// is lost. Reset (synchronous, active high) empties the buffer and returns
// the scanner to between tokens at offset 0, line 1, column 1.
module source_text_tokenizer_top (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   input  logic [7:0]   req_tdata,  // character
   input  logic         req_tuser,  // end_of_input
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   output logic [103:0] rsp_tdata,  // token_kind, start_offset, token_length,
                                    // first_line, first_column, final_line,
                                    // final_column, zero pad
   output logic         rsp_tlast   // is_last
);
   import stt_pkg::*;

   logic step;
   logic [1:0] count;
   token_type tok0, tok1;
   token_type buf_ff [2];
   token_type buf_in [2];
   logic [1:0] fill_ff, fill_in;
   logic [1:0] last_ff, last_in;
   logic pop;

   assign pop = rsp_tvalid && rsp_tready;
   // accept when the buffer will be empty after this cycle's pop
   assign req_tready = (fill_ff == 2'd0) || (fill_ff == 2'd1 && rsp_tready);
   assign step = req_tvalid && req_tready;

   stt_scan u_scan (
      .clock(clock), .reset(reset), .step(step),
      .character(req_tdata), .end_of_input(req_tuser),
      .count(count), .tok0(tok0), .tok1(tok1));

   always_comb begin
      buf_in = buf_ff; fill_in = fill_ff; last_in = last_ff;
      if (pop) begin
         buf_in[0] = buf_ff[1]; last_in[0] = last_ff[1];
         fill_in = fill_ff - 2'd1;
      end
      if (step) begin
         buf_in[0] = tok0; buf_in[1] = tok1;
         last_in = (count == 2'd2) ? 2'b10 : 2'b01;
         fill_in = count;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fill_ff <= '0;
      end else begin
         fill_ff <= fill_in;
      end
      buf_ff  <= buf_in;
      last_ff <= last_in;
   end

   assign rsp_tvalid = fill_ff != 2'd0;
   assign rsp_tlast  = last_ff[0];
   assign rsp_tdata  = {1'b0, buf_ff[0].final_col, buf_ff[0].final_line,
                        buf_ff[0].first_col, buf_ff[0].first_line,
                        buf_ff[0].length, buf_ff[0].start, buf_ff[0].kind};
endmodule
